// File: rtl/hduart_pkg.sv
// Package for the half-duplex UART with transmit and receive FIFOs.
// Holds FIFO sizes, derived widths and the command, status and line mode codes.
// No dependencies; used by half_duplex_uart_with_fifos.
package hduart_pkg;

   // FIFO sizes and derived widths
   localparam int unsigned TX_DEPTH = 16;
   localparam int unsigned RX_DEPTH = 16;
   localparam int unsigned TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam int unsigned RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int unsigned TX_LVL_W = $clog2(TX_DEPTH + 1);
   localparam int unsigned RX_LVL_W = $clog2(RX_DEPTH + 1);
   localparam int unsigned TX_SUM_W = TX_LVL_W + 1;
   localparam int unsigned RX_SUM_W = RX_LVL_W + 1;

   // serial frame: start bit, eight data bits, stop bit
   localparam logic [3:0] BIT_LAST_DATA = 4'd8;
   localparam logic [3:0] BIT_STOP      = 4'd9;

   // word layout
   localparam int unsigned REQ_DATA_W = 16;
   localparam int unsigned RSP_DATA_W = 24;

   // command codes
   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_PUSH = 2'd1;
   localparam logic [1:0] CMD_POP  = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_TX_FULL  = 2'd1;
   localparam logic [1:0] ST_RX_EMPTY = 2'd2;

   // line modes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_TX   = 2'd1;
   localparam logic [1:0] MODE_RX   = 2'd2;

   // bit period after reset
   localparam logic [7:0] BIT_PERIOD_RST = 8'd104;

endpackage

// File: rtl/half_duplex_uart_with_fifos.sv
// Half-duplex 8N1 UART, LSB first, with 16-entry transmit and receive FIFOs.
// One request word is one baud-timer tick plus an optional push or pop.
// Depends on hduart_pkg.
//
//   channel   | direction | tdata / tuser
//   ----------+-----------+--------------------------------------------------
//   req_      | in        | tdata: tx_data, rx_line; tuser: command
//   rsp_      | out       | tdata: tx_line, rx_data, rx_count, tx_count,
//             |           |        status, line_mode, rx_dropped
//   csr_      | in        | wdata: bit_period
//
// One word per cycle: the tick's line and FIFO work is one pass of logic from
// the state registers into the response register, so a word is accepted in
// every cycle while the response register is free or being drained.
// A stall on rsp_ holds req_tready low; the tick timer only advances on
// accepted words. Synchronous reset clears control state; FIFO entries are
// undefined until written and need no clearing pass.
module half_duplex_uart_with_fifos (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] tx_data, [8] rx_line, [15:9] zero
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [0] tx_line, [8:1] rx_data, [13:9] rx_count,
                                    // [18:14] tx_count, [20:19] status,
                                    // [22:21] line_mode, [23] rx_dropped
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   // configuration
   logic [7:0] bit_period_ff;

   // line state
   logic [1:0] mode_ff,    mode_in;
   logic [7:0] tick_ff,    tick_in;
   logic [3:0] bit_idx_ff, bit_idx_in;
   logic [7:0] shift_ff,   shift_in;
   logic       last_rx_ff, last_rx_in;
   logic       tx_out_ff,  tx_out_in;

   // FIFO storage and pointers
   logic [7:0] tx_mem [hduart_pkg::TX_DEPTH];
   logic [7:0] rx_mem [hduart_pkg::RX_DEPTH];
   logic [hduart_pkg::TX_PTR_W-1:0] tx_head_ff, tx_head_in, tx_head_inc, tx_wr_addr;
   logic [hduart_pkg::RX_PTR_W-1:0] rx_head_ff, rx_head_in, rx_head_inc, rx_wr_addr;
   logic [hduart_pkg::TX_LVL_W-1:0] tx_lvl_ff, tx_lvl_in;
   logic [hduart_pkg::RX_LVL_W-1:0] rx_lvl_ff, rx_lvl_in;
   logic [hduart_pkg::TX_SUM_W-1:0] tx_sum;
   logic [hduart_pkg::RX_SUM_W-1:0] rx_sum;
   logic       tx_wr_en;
   logic       rx_wr_en;

   // response register
   logic                            rsp_valid_ff;
   logic [hduart_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // per-word decode and helpers
   logic       accept;
   logic [1:0] command;
   logic [7:0] tx_data;
   logic       rx_line;
   logic       rx_edge;
   logic [7:0] full_per;
   logic [7:0] half_per;
   logic [7:0] tick_dec;
   logic [2:0] rx_sel;
   logic [7:0] rx_data;
   logic [1:0] status;
   logic       dropped;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign command = req_tuser;
   assign tx_data = req_tdata[7:0];
   assign rx_line = req_tdata[8];
   assign rx_edge = rx_line != last_rx_ff;

   // timing constants from the bit period; zero acts as one
   assign full_per = (bit_period_ff == 8'd0) ? 8'd1 : bit_period_ff;
   assign half_per = (bit_period_ff[7:1] == 7'd0) ? 8'd1 : {1'b0, bit_period_ff[7:1]};
   assign tick_dec = (tick_ff == 8'd0) ? 8'd0 : tick_ff - 8'd1;
   assign rx_sel   = 3'(bit_idx_ff - 4'd1);

   // head advance with wrap
   assign tx_head_inc = (tx_head_ff == hduart_pkg::TX_PTR_W'(hduart_pkg::TX_DEPTH - 1)) ?
                        '0 : tx_head_ff + hduart_pkg::TX_PTR_W'(1);
   assign rx_head_inc = (rx_head_ff == hduart_pkg::RX_PTR_W'(hduart_pkg::RX_DEPTH - 1)) ?
                        '0 : rx_head_ff + hduart_pkg::RX_PTR_W'(1);

   // tail slot: head plus level, wrapped (a take and a push in one tick keep the sum)
   assign tx_sum = hduart_pkg::TX_SUM_W'(tx_head_ff) + hduart_pkg::TX_SUM_W'(tx_lvl_ff);
   assign rx_sum = hduart_pkg::RX_SUM_W'(rx_head_ff) + hduart_pkg::RX_SUM_W'(rx_lvl_ff);
   assign tx_wr_addr = hduart_pkg::TX_PTR_W'(
      (tx_sum >= hduart_pkg::TX_SUM_W'(hduart_pkg::TX_DEPTH)) ?
      tx_sum - hduart_pkg::TX_SUM_W'(hduart_pkg::TX_DEPTH) : tx_sum);
   assign rx_wr_addr = hduart_pkg::RX_PTR_W'(
      (rx_sum >= hduart_pkg::RX_SUM_W'(hduart_pkg::RX_DEPTH)) ?
      rx_sum - hduart_pkg::RX_SUM_W'(hduart_pkg::RX_DEPTH) : rx_sum);

   // line phase, then command phase, for one tick
   always_comb begin
      mode_in    = mode_ff;
      tick_in    = tick_ff;
      bit_idx_in = bit_idx_ff;
      shift_in   = shift_ff;
      tx_out_in  = tx_out_ff;
      last_rx_in = rx_line;
      tx_head_in = tx_head_ff;
      tx_lvl_in  = tx_lvl_ff;
      rx_head_in = rx_head_ff;
      rx_lvl_in  = rx_lvl_ff;
      tx_wr_en   = 1'b0;
      rx_wr_en   = 1'b0;
      rx_data    = 8'd0;
      status     = hduart_pkg::ST_OK;
      dropped    = 1'b0;

      // line phase
      unique case (mode_ff)
         hduart_pkg::MODE_TX: begin
            if (tick_dec == 8'd0) begin
               bit_idx_in = bit_idx_ff + 4'd1;
               tick_in    = full_per;
               if (bit_idx_ff < hduart_pkg::BIT_LAST_DATA) begin
                  tx_out_in = shift_ff[bit_idx_ff[2:0]];
               end else if (bit_idx_ff == hduart_pkg::BIT_LAST_DATA) begin
                  tx_out_in = 1'b1;
               end else if (tx_lvl_ff != '0) begin
                  // next queued byte follows the stop bit at once
                  shift_in   = tx_mem[tx_head_ff];
                  tx_head_in = tx_head_inc;
                  tx_lvl_in  = tx_lvl_ff - hduart_pkg::TX_LVL_W'(1);
                  bit_idx_in = 4'd0;
                  tx_out_in  = 1'b0;
               end else begin
                  mode_in    = hduart_pkg::MODE_IDLE;
                  tx_out_in  = 1'b1;
                  bit_idx_in = 4'd0;
                  tick_in    = 8'd0;
               end
            end else begin
               tick_in = tick_dec;
            end
         end
         hduart_pkg::MODE_RX: begin
            if (rx_edge) begin
               // resync the sample point on any edge
               tick_in = half_per;
            end else if (tick_dec == 8'd0) begin
               tick_in = full_per;
               if (bit_idx_ff >= 4'd1 && bit_idx_ff <= hduart_pkg::BIT_LAST_DATA) begin
                  shift_in[rx_sel] = shift_ff[rx_sel] | rx_line;
               end
               if (bit_idx_ff >= hduart_pkg::BIT_STOP) begin
                  // stop sample: store the byte, or drop it if the FIFO is full
                  if (rx_lvl_ff < hduart_pkg::RX_LVL_W'(hduart_pkg::RX_DEPTH)) begin
                     rx_wr_en  = 1'b1;
                     rx_lvl_in = rx_lvl_ff + hduart_pkg::RX_LVL_W'(1);
                  end else begin
                     dropped = 1'b1;
                  end
                  mode_in    = hduart_pkg::MODE_IDLE;
                  bit_idx_in = 4'd0;
                  tick_in    = 8'd0;
               end else begin
                  bit_idx_in = bit_idx_ff + 4'd1;
               end
            end else begin
               tick_in = tick_dec;
            end
         end
         default: begin
            // falling edge on an idle line starts a reception
            if (last_rx_ff && !rx_line) begin
               mode_in    = hduart_pkg::MODE_RX;
               tick_in    = half_per;
               bit_idx_in = 4'd0;
               shift_in   = 8'd0;
            end
         end
      endcase

      // command phase
      case (command)
         hduart_pkg::CMD_PUSH: begin
            if (tx_lvl_in < hduart_pkg::TX_LVL_W'(hduart_pkg::TX_DEPTH)) begin
               tx_wr_en  = 1'b1;
               tx_lvl_in = tx_lvl_in + hduart_pkg::TX_LVL_W'(1);
            end else begin
               status = hduart_pkg::ST_TX_FULL;
            end
            // start sending; this aborts a reception in progress
            if (mode_in != hduart_pkg::MODE_TX && tx_lvl_in != '0) begin
               shift_in   = (tx_lvl_ff == '0) ? tx_data : tx_mem[tx_head_ff];
               tx_head_in = tx_head_inc;
               tx_lvl_in  = tx_lvl_in - hduart_pkg::TX_LVL_W'(1);
               mode_in    = hduart_pkg::MODE_TX;
               bit_idx_in = 4'd0;
               tick_in    = full_per;
               tx_out_in  = 1'b0;
            end
         end
         hduart_pkg::CMD_POP: begin
            if (rx_lvl_in != '0) begin
               // bypass the byte stored this tick when the FIFO was empty
               rx_data    = (rx_lvl_ff == '0) ? shift_ff : rx_mem[rx_head_ff];
               rx_head_in = rx_head_inc;
               rx_lvl_in  = rx_lvl_in - hduart_pkg::RX_LVL_W'(1);
            end else begin
               status = hduart_pkg::ST_RX_EMPTY;
            end
         end
         default: begin
         end
      endcase

      rsp_data_in = {dropped, mode_in, status,
                     5'(tx_lvl_in), 5'(rx_lvl_in), rx_data, tx_out_in};
   end

   // hold the bit period
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= hduart_pkg::BIT_PERIOD_RST;
      end else if (csr_we) begin
         bit_period_ff <= csr_wdata;
      end
   end

   // advance line and FIFO state on each accepted word
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= hduart_pkg::MODE_IDLE;
         tick_ff    <= 8'd0;
         bit_idx_ff <= 4'd0;
         shift_ff   <= 8'd0;
         last_rx_ff <= 1'b1;
         tx_out_ff  <= 1'b1;
         tx_head_ff <= '0;
         tx_lvl_ff  <= '0;
         rx_head_ff <= '0;
         rx_lvl_ff  <= '0;
      end else if (accept) begin
         mode_ff    <= mode_in;
         tick_ff    <= tick_in;
         bit_idx_ff <= bit_idx_in;
         shift_ff   <= shift_in;
         last_rx_ff <= last_rx_in;
         tx_out_ff  <= tx_out_in;
         tx_head_ff <= tx_head_in;
         tx_lvl_ff  <= tx_lvl_in;
         rx_head_ff <= rx_head_in;
         rx_lvl_ff  <= rx_lvl_in;
      end
   end

   // write FIFO entries
   always_ff @(posedge clock) begin
      if (accept && tx_wr_en) begin
         tx_mem[tx_wr_addr] <= tx_data;
      end
      if (accept && rx_wr_en) begin
         rx_mem[rx_wr_addr] <= shift_ff;
      end
   end

   // response register: load on accept, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// File: verif/half_duplex_uart_with_fifos_tb.sv
// Testbench for half_duplex_uart_with_fifos: drives tick words, checks every response word.
// Uses a predictor of the serial line and both FIFOs, plus a small response scoreboard.
// Depends on hduart_pkg and the RTL top level only.
module half_duplex_uart_with_fifos_tb;
   timeunit 1ns;
   timeprecision 1ps;

   // spare command code, treated by the block as a bare tick
   localparam logic [1:0] CMD_SPARE = 2'd3;
   localparam int MAX_REPORTS = 10;

   // response word, lowest field in bit 0
   typedef struct packed {
      logic       rx_dropped;
      logic [1:0] line_mode;
      logic [1:0] status;
      logic [4:0] tx_count;
      logic [4:0] rx_count;
      logic [7:0] rx_data;
      logic       tx_line;
   } uart_rsp_type;

   // Predicts the block tick by tick and checks response words in order.
   class uart_scoreboard_type;
      logic [7:0]   period_ticks;
      logic [1:0]   mode;
      logic [7:0]   ticks_left;
      logic [3:0]   bit_idx;
      logic [7:0]   shifter;
      logic         last_line;
      logic         tx_pin;
      logic [7:0]   tx_fifo[$];
      logic [7:0]   rx_fifo[$];
      uart_rsp_type rsp_words_due[$];
      int           fails;

      function new();
         period_ticks = hduart_pkg::BIT_PERIOD_RST;
         mode = hduart_pkg::MODE_IDLE;
         ticks_left = '0;
         bit_idx = '0;
         shifter = '0;
         last_line = 1'b1;
         tx_pin = 1'b1;
         fails = 0;
      endfunction

      function void set_period(logic [7:0] value);
         period_ticks = value;
      endfunction

      function logic [7:0] full_ticks();
         return (period_ticks == 8'd0) ? 8'd1 : period_ticks;
      endfunction

      function void load_tx_byte();
         shifter = tx_fifo.pop_front();
         mode = hduart_pkg::MODE_TX;
         bit_idx = '0;
         ticks_left = full_ticks();
         tx_pin = 1'b0;
      endfunction

      // advance one tick: line phase on the old state, then the command
      function void note_req(logic [1:0] cmd, logic [7:0] data, logic line);
         uart_rsp_type r;
         logic [7:0]   half;
         logic         line_moved;
         r = '0;
         half = ((period_ticks >> 1) == 8'd0) ? 8'd1 : (period_ticks >> 1);
         line_moved = (line != last_line);
         case (mode)
            hduart_pkg::MODE_TX: begin
               if (ticks_left != 8'd0) ticks_left--;
               if (ticks_left == 8'd0) begin
                  bit_idx++;
                  ticks_left = full_ticks();
                  if (bit_idx <= hduart_pkg::BIT_LAST_DATA) begin
                     tx_pin = shifter[bit_idx - 1];
                  end else if (bit_idx == hduart_pkg::BIT_STOP) begin
                     tx_pin = 1'b1;
                  end else if (tx_fifo.size() > 0) begin
                     load_tx_byte();
                  end else begin
                     mode = hduart_pkg::MODE_IDLE;
                     tx_pin = 1'b1;
                     bit_idx = '0;
                     ticks_left = '0;
                  end
               end
            end
            hduart_pkg::MODE_RX: begin
               // any edge re-centers the sample point, no sample on that tick
               if (line_moved) begin
                  ticks_left = half;
               end else begin
                  if (ticks_left != 8'd0) ticks_left--;
                  if (ticks_left == 8'd0) begin
                     ticks_left = full_ticks();
                     if (bit_idx >= 4'd1 && bit_idx <= hduart_pkg::BIT_LAST_DATA)
                        shifter[bit_idx - 1] = shifter[bit_idx - 1] | line;
                     if (bit_idx >= hduart_pkg::BIT_STOP) begin
                        if (rx_fifo.size() < hduart_pkg::RX_DEPTH)
                           rx_fifo.push_back(shifter);
                        else
                           r.rx_dropped = 1'b1;
                        mode = hduart_pkg::MODE_IDLE;
                        bit_idx = '0;
                        ticks_left = '0;
                     end else begin
                        bit_idx++;
                     end
                  end
               end
            end
            default: begin
               if (last_line && !line) begin
                  mode = hduart_pkg::MODE_RX;
                  ticks_left = half;
                  bit_idx = '0;
                  shifter = '0;
               end
            end
         endcase
         last_line = line;

         if (cmd == hduart_pkg::CMD_PUSH) begin
            if (tx_fifo.size() < hduart_pkg::TX_DEPTH) tx_fifo.push_back(data);
            else r.status = hduart_pkg::ST_TX_FULL;
            if (mode != hduart_pkg::MODE_TX && tx_fifo.size() > 0) load_tx_byte();
         end else if (cmd == hduart_pkg::CMD_POP) begin
            if (rx_fifo.size() > 0) r.rx_data = rx_fifo.pop_front();
            else r.status = hduart_pkg::ST_RX_EMPTY;
         end

         r.tx_line = tx_pin;
         r.rx_count = 5'(rx_fifo.size());
         r.tx_count = 5'(tx_fifo.size());
         r.line_mode = mode;
         rsp_words_due.push_back(r);
      endfunction

      function void check_rsp(logic [23:0] raw);
         uart_rsp_type got, want;
         got = raw;
         if (rsp_words_due.size() == 0) begin
            fails++;
            if (fails <= MAX_REPORTS) $display("unexpected response word %h", raw);
            return;
         end
         want = rsp_words_due.pop_front();
         if (got.tx_line !== want.tx_line || got.rx_data !== want.rx_data ||
             got.rx_count !== want.rx_count || got.tx_count !== want.tx_count ||
             got.status !== want.status || got.line_mode !== want.line_mode ||
             got.rx_dropped !== want.rx_dropped) begin
            fails++;
            if (fails <= MAX_REPORTS)
               $display("mismatch: exp tx=%b rxd=%h rxc=%0d txc=%0d st=%0d md=%0d drp=%b",
                        want.tx_line, want.rx_data, want.rx_count, want.tx_count,
                        want.status, want.line_mode, want.rx_dropped,
                        " | act tx=%b rxd=%h rxc=%0d txc=%0d st=%0d md=%0d drp=%b",
                        got.tx_line, got.rx_data, got.rx_count, got.tx_count,
                        got.status, got.line_mode, got.rx_dropped);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [hduart_pkg::REQ_DATA_W-1:0] req_tdata = '0;  // [7:0] tx_data, [8] rx_line,
                                                       // [15:9] zero
   logic [1:0]  req_tuser = '0;  // [1:0] command
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;       // [0] tx_line, [8:1] rx_data, [13:9] rx_count,
                                 // [18:14] tx_count, [20:19] status,
                                 // [22:21] line_mode, [23] rx_dropped
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = '0;

   uart_scoreboard_type sb;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_request = 0;
   int hold_left = 0;
   int words_sent = 0;
   int period_now = hduart_pkg::BIT_PERIOD_RST;

   half_duplex_uart_with_fifos dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   // response side: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // note accepted request words, check accepted response words
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_req(req_tuser, req_tdata[7:0], req_tdata[8]);
         if (rsp_tvalid && rsp_tready) sb.check_rsp(rsp_tdata);
      end
   end

   // offer one word, with an optional gap first; return at the accepting edge
   task automatic send_word(input logic [1:0] cmd, input logic [7:0] data, input logic line);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 3) : 0;
      repeat (gap) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'b0, line, data};
      req_tuser <= cmd;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   // drop valid and hold until every predicted response has come back
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.rsp_words_due.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic csr_write(input logic [7:0] value);
      csr_wdata <= value;
      csr_we <= 1'b1;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.set_period(value);
      period_now = value;
   endtask

   // tick with the line high until neither a transfer nor a reception is running
   task automatic settle_line();
      wait_drained();
      while (sb.mode != hduart_pkg::MODE_IDLE) begin
         repeat (20) send_word(hduart_pkg::CMD_TICK, 8'($urandom_range(255)), 1'b1);
         wait_drained();
      end
   endtask

   // serial frame on the receive line: start, eight data bits LSB first, stop
   task automatic rx_frame(input logic [7:0] value, input bit jitter, input int pop_pct,
                           input bit broken);
      int cut, len, b;
      logic level;
      logic [1:0] cmd;
      cut = broken ? $urandom_range(1, 9) : 10;
      for (b = 0; b < cut; b++) begin
         level = (b == 0) ? 1'b0 : (b == 9) ? 1'b1 : value[b - 1];
         len = jitter ? $urandom_range(period_now - 1, period_now + 1) : period_now;
         repeat (len) begin
            cmd = ($urandom_range(99) < pop_pct) ? hduart_pkg::CMD_POP : hduart_pkg::CMD_TICK;
            send_word(cmd, 8'($urandom_range(255)), level);
         end
      end
      // a cut frame is either abandoned on the line or aborted by a push
      if (broken && $urandom_range(1))
         send_word(hduart_pkg::CMD_PUSH, 8'($urandom_range(255)), 1'b1);
      repeat ($urandom_range(1, period_now))
         send_word(hduart_pkg::CMD_TICK, 8'($urandom_range(255)), 1'b1);
   endtask

   // queue a few bytes, then tick long enough for them to go out
   task automatic tx_burst(input int count);
      int n;
      logic [1:0] cmd;
      repeat (count) send_word(hduart_pkg::CMD_PUSH, 8'($urandom_range(255)), 1'b1);
      n = count * 10 * period_now + period_now + $urandom_range(0, 5);
      repeat (n) begin
         cmd = ($urandom_range(99) < 5) ? hduart_pkg::CMD_POP : hduart_pkg::CMD_TICK;
         send_word(cmd, 8'($urandom_range(255)), ($urandom_range(9) != 0));
      end
      repeat (2) send_word(hduart_pkg::CMD_TICK, 8'($urandom_range(255)), 1'b1);
   endtask

   task automatic noise(input int count);
      repeat (count)
         send_word(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   // mostly clean frames with random content, the rest bursts, cut frames and noise
   task automatic random_mix(input int count);
      int stop_at, pick;
      stop_at = words_sent + count;
      while (words_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 55)
            rx_frame(8'($urandom_range(255)), 1'($urandom_range(1)), 3, 1'b0);
         else if (pick < 65)
            rx_frame(8'($urandom_range(255)), 1'($urandom_range(1)), 3, 1'b1);
         else if (pick < 85)
            tx_burst($urandom_range(1, 2));
         else
            noise($urandom_range(5, 20));
      end
   endtask

   initial begin
      #(5_000_000);
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      int n;
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop, spare command, reception started then aborted, pushes
      send_word(hduart_pkg::CMD_POP, 8'h00, 1'b1);
      send_word(CMD_SPARE, 8'hFF, 1'b1);
      send_word(hduart_pkg::CMD_TICK, 8'h00, 1'b0);
      send_word(hduart_pkg::CMD_TICK, 8'hFF, 1'b0);
      send_word(hduart_pkg::CMD_TICK, 8'h00, 1'b1);
      send_word(hduart_pkg::CMD_TICK, 8'h00, 1'b0);
      send_word(hduart_pkg::CMD_PUSH, 8'h00, 1'b0);
      send_word(hduart_pkg::CMD_PUSH, 8'hFF, 1'b1);
      send_word(hduart_pkg::CMD_PUSH, 8'h55, 1'b0);
      send_word(hduart_pkg::CMD_PUSH, 8'hAA, 1'b1);
      send_word(hduart_pkg::CMD_PUSH, 8'hF0, 1'b0);
      send_word(hduart_pkg::CMD_POP, 8'hFF, 1'b1);
      send_word(hduart_pkg::CMD_TICK, 8'hFF, 1'b1);
      send_word(CMD_SPARE, 8'h00, 1'b0);
      wait_drained();

      // shortest bit period used here, sender rarely idle, receiver mostly stalled
      csr_write(8'd10);
      send_idle_pct = 22;
      recv_idle_pct = 81;
      random_mix(120);
      wait_drained();

      // longest bit period used here: start a reception, re-center it, then abort it with a push
      csr_write(8'd254);
      repeat (3) send_word(hduart_pkg::CMD_TICK, 8'($urandom_range(255)), 1'b1);
      repeat (5) send_word(hduart_pkg::CMD_TICK, 8'($urandom_range(255)), 1'b0);
      repeat (3) send_word(hduart_pkg::CMD_TICK, 8'($urandom_range(255)), 1'b1);
      send_word(hduart_pkg::CMD_PUSH, 8'($urandom_range(255)), 1'b1);
      repeat (30) send_word(hduart_pkg::CMD_TICK, 8'($urandom_range(255)), 1'b0);
      wait_drained();

      // mid-range period, idling swapped
      csr_write(8'($urandom_range(10, 20)));
      send_idle_pct = 81;
      recv_idle_pct = 22;
      random_mix(120);
      wait_drained();

      // no idling: receive frames under a long response hold-off
      csr_write(8'd10);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      settle_line();
      n = sb.rx_fifo.size();
      repeat (n) send_word(hduart_pkg::CMD_POP, 8'($urandom_range(255)), 1'b1);
      hold_request = 300;
      repeat (2) rx_frame(8'($urandom_range(255)), 1'b0, 0, 1'b0);
      repeat (4) send_word(hduart_pkg::CMD_POP, 8'($urandom_range(255)), 1'b1);

      // overrun the transmit FIFO
      repeat (18) send_word(hduart_pkg::CMD_PUSH, 8'($urandom_range(255)), 1'b1);
      repeat (100) send_word(hduart_pkg::CMD_TICK, 8'($urandom_range(255)), 1'b1);

      // drain with a limit, then let the response register settle before the verdict
      req_tvalid <= 1'b0;
      @(posedge clock);
      n = 0;
      while (sb.rsp_words_due.size() != 0 && n < 20000) begin
         @(posedge clock);
         n++;
      end
      repeat (5) @(posedge clock);
      if (sb.fails == 0 && sb.rsp_words_due.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: half_duplex_uart_with_fifos.f
rtl/hduart_pkg.sv
rtl/half_duplex_uart_with_fifos.sv
verif/half_duplex_uart_with_fifos_tb.sv
